// File: hw/rtl/hsa_pkg.sv
// Shared types and constants for the HSL saturation adjust pipeline.
`default_nettype none
package hsa_pkg;

  localparam int unsigned ChanW  = 8;   // channel width
  localparam int unsigned OpW    = 12;  // signed multiplier operand width
  localparam int unsigned NumW   = 20;  // signed numerator width
  localparam int unsigned DenW   = 10;  // denominator width, at most 510
  localparam int unsigned RemW   = 17;  // remainder width, below 256 * 510
  localparam int unsigned QuoW   = 8;   // quotient bits, one per divide stage
  localparam int unsigned NumCh  = 3;
  localparam int unsigned Pct    = 100;
  localparam int unsigned GrayDen = 1;
  localparam int unsigned DesatDen = 200;
  localparam int unsigned ChanMax = 255;
  localparam int unsigned ChanSpan = 510;

  // Input pixel transaction
  typedef struct packed {
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic [ChanW-1:0] chan_c;
  } pix_t;

  // Result pixel transaction
  typedef struct packed {
    logic [ChanW-1:0] out_a;
    logic [ChanW-1:0] out_b;
    logic [ChanW-1:0] out_c;
  } res_t;

  // Per-pixel state carried through the divider stages
  typedef struct packed {
    logic [NumCh-1:0][RemW-1:0] rem;
    logic [NumCh-1:0][QuoW-1:0] quo;
    logic [NumCh-1:0]           neg;
    logic [NumCh-1:0]           big;
    logic [DenW-1:0]            den;
  } div_t;

endpackage
`default_nettype wire

// File: hw/rtl/hsl_saturation_adjust_top.sv
// Pipelined HSL saturation adjust of one RGB-style pixel per clock.
//
// Usage: write the signed percent amount through cfg_we_i / cfg_wdata_i
// while no pixel is in flight. Present a pixel on pix_i with start_i high;
// busy_o is always low, so a transaction is taken at every edge with
// start_i high. One pixel enters per clock, sustained.
// Each result appears on res_o with res_valid_o high for exactly one cycle,
// after passing fourteen register stages: input register, min/max, operand
// select, multiply-add, range check, eight restoring divide stages, one
// quotient bit each, then round and saturate. Results leave in order.
// The receiver cannot stall: results are never held back.
// Reset clears the amount to zero and all pipeline valid bits; pixels
// in flight at reset are dropped.
`default_nettype none
module hsl_saturation_adjust_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire hsa_pkg::pix_t pix_i,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  output logic               res_valid_o,
  output hsa_pkg::res_t      res_o
);
  import hsa_pkg::*;

  localparam int unsigned Lat = 14;

  logic signed [7:0] amount_q;

  // Stage 1: input register
  logic                               v1_q;
  logic [NumCh-1:0][ChanW-1:0]        c1_q;
  logic signed [7:0]                  a1_q;
  // Stage 2: min/max terms
  logic                               v2_q;
  logic [NumCh-1:0][ChanW-1:0]        c2_q;
  logic [ChanW-1:0]                   d2_q, q2_q;
  logic [ChanW:0]                     s2_q;
  logic signed [7:0]                  a2_q;
  // Stage 3: multiplier operands
  logic                               v3_q;
  logic signed [NumCh-1:0][OpW-1:0]   opa_q, opb_q, opc_q, opd_q;
  logic [DenW-1:0]                    den3_q;
  // Stage 4: numerators
  logic                               v4_q;
  logic [NumCh-1:0][NumW-1:0]         num4_q;
  logic [DenW-1:0]                    den4_q;
  // Divider stages
  logic                               dv_q [0:QuoW];
  div_t                               div_q [0:QuoW];
  // Output
  logic                               rv_q;
  res_t                               res_q;

  assign busy_o = 1'b0;

  // Hold the amount register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= '0;
    end else if (cfg_we_i) begin
      amount_q <= $signed(cfg_wdata_i);
    end
  end

  // Stage 1: capture the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= {pix_i.chan_a, pix_i.chan_b, pix_i.chan_c};
    a1_q <= amount_q;
  end

  // Stage 2: max, min, difference, sum and lightness denominator
  logic [ChanW-1:0] mx, mn, ab_mx, ab_mn;
  logic [ChanW:0]   sum;
  always_comb begin
    ab_mx = (c1_q[2] > c1_q[1]) ? c1_q[2] : c1_q[1];
    ab_mn = (c1_q[2] < c1_q[1]) ? c1_q[2] : c1_q[1];
    mx    = (c1_q[0] > ab_mx) ? c1_q[0] : ab_mx;
    mn    = (c1_q[0] < ab_mn) ? c1_q[0] : ab_mn;
    sum   = {1'b0, mx} + {1'b0, mn};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q <= c1_q;
    d2_q <= mx - mn;
    s2_q <= sum;
    q2_q <= (sum <= (ChanW+1)'(ChanMax)) ? sum[ChanW-1:0]
                                         : ChanW'((ChanW+1)'(ChanSpan) - sum);
    a2_q <= a1_q;
  end

  // Stage 3: pick the branch and the multiplier operands
  logic signed [19:0]                lhs, rhs, amt_w;
  logic                              gray, pos, br1;
  logic signed [OpW-1:0]             amt_op, d_op, q_op, s_op;
  logic signed [NumCh-1:0][OpW-1:0]  opa_d, opb_d, opc_d, opd_d;
  logic [DenW-1:0]                   den3_d;
  logic signed [OpW-1:0]             off, c_op;
  always_comb begin
    amt_w  = {{12{a2_q[7]}}, a2_q};
    lhs    = $signed({12'b0, d2_q}) * 20'sd100;
    rhs    = (20'sd100 - amt_w) * $signed({12'b0, q2_q});
    gray   = (d2_q == '0);
    pos    = (a2_q > 8'sd0);
    br1    = pos && (lhs >= rhs);
    amt_op = {{(OpW-8){a2_q[7]}}, a2_q};
    d_op   = $signed({{(OpW-ChanW){1'b0}}, d2_q});
    q_op   = $signed({{(OpW-ChanW){1'b0}}, q2_q});
    s_op   = $signed({{(OpW-ChanW-1){1'b0}}, s2_q});
    if (gray) begin
      den3_d = DenW'(GrayDen);
    end else if (br1) begin
      den3_d = DenW'({d2_q, 1'b0});
    end else if (pos) begin
      den3_d = DenW'(OpW'(2) * (OpW'(Pct) - amt_op));
    end else begin
      den3_d = DenW'(DesatDen);
    end
    for (int i = 0; i < NumCh; i++) begin
      c_op = $signed({{(OpW-ChanW){1'b0}}, c2_q[i]});
      off  = (c_op <<< 1) - s_op;
      if (gray) begin
        opa_d[i] = c_op;
        opb_d[i] = OpW'(1);
        opc_d[i] = '0;
        opd_d[i] = '0;
      end else if (br1) begin
        opa_d[i] = c_op;
        opb_d[i] = d_op <<< 1;
        opc_d[i] = off;
        opd_d[i] = q_op - d_op;
      end else if (pos) begin
        opa_d[i] = c_op;
        opb_d[i] = OpW'(2) * (OpW'(Pct) - amt_op);
        opc_d[i] = off;
        opd_d[i] = amt_op;
      end else begin
        opa_d[i] = OpW'(Pct);
        opb_d[i] = s_op;
        opc_d[i] = off;
        opd_d[i] = OpW'(Pct) + amt_op;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    opc_q  <= opc_d;
    opd_q  <= opd_d;
    den3_q <= den3_d;
  end

  // Stage 4: two products and their sum per channel
  logic signed [2*OpW-1:0] p1, p2, psum;
  logic [NumCh-1:0][NumW-1:0] num4_d;
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      p1        = $signed(opa_q[i]) * $signed(opb_q[i]);
      p2        = $signed(opc_q[i]) * $signed(opd_q[i]);
      psum      = p1 + p2;
      num4_d[i] = psum[NumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num4_q <= num4_d;
    den4_q <= den3_q;
  end

  // Stage 5: flag results that saturate, load the divider
  div_t div0_d;
  always_comb begin
    div0_d     = '0;
    div0_d.den = den4_q;
    for (int i = 0; i < NumCh; i++) begin
      div0_d.neg[i] = num4_q[i][NumW-1];
      div0_d.big[i] = !num4_q[i][NumW-1] &&
                      (num4_q[i][NumW-2:0] >= (NumW-1)'({den4_q, 8'b0}));
      div0_d.rem[i] = num4_q[i][RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= div0_d;
  end

  // Restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int unsigned Sh = QuoW - 1 - k;
    div_t            nxt;
    logic [RemW-1:0] trial;
    always_comb begin
      nxt   = div_q[k];
      trial = RemW'({7'b0, div_q[k].den} << Sh);
      for (int i = 0; i < NumCh; i++) begin
        if (div_q[k].rem[i] >= trial) begin
          nxt.rem[i]     = div_q[k].rem[i] - trial;
          nxt.quo[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[k+1] <= nxt;
    end
  end

  // Output stage: round half to even and saturate
  logic [NumCh-1:0][ChanW-1:0] fin;
  logic [RemW:0]               twor;
  logic                        up;
  logic [ChanW:0]              rnd;
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      twor = {div_q[QuoW].rem[i], 1'b0};
      up   = (twor > (RemW+1)'(div_q[QuoW].den)) ||
             ((twor == (RemW+1)'(div_q[QuoW].den)) && div_q[QuoW].quo[i][0]);
      rnd  = {1'b0, div_q[QuoW].quo[i]} + (ChanW+1)'(up);
      if (div_q[QuoW].neg[i]) begin
        fin[i] = '0;
      end else if (div_q[QuoW].big[i] || rnd[ChanW]) begin
        fin[i] = ChanW'(ChanMax);
      end else begin
        fin[i] = rnd[ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= dv_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= '{out_a: fin[2], out_b: fin[1], out_c: fin[0]};
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // Every accepted pixel yields a strobe at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat res_valid_o)
    else $error("result strobe missing after pipeline latency");

  // Divider never runs on a zero denominator
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] |-> (div_q[0].den != '0))
    else $error("zero denominator entered divider");

  // A strobe only follows a valid divider output
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(dv_q[QuoW]))
    else $error("result strobe without divider output");

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the HSL saturation adjust pipeline.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsa_pkg::*;

  localparam int Latency = 14;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  pix_t       pix_i;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       res_valid_o;
  res_t       res_o;

  pix_t pixel_q[$];
  res_t adjusted_q[$];
  logic signed [7:0] sat_amount;
  int   mismatch_cnt;
  bit   feed_hold;
  int   burst_left;
  int   gap_left;

  hsl_saturation_adjust_top DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .pix_i,
    .cfg_we_i, .cfg_wdata_i, .res_valid_o, .res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Round num/den to nearest with ties to even, then clamp to a channel.
  function automatic logic [7:0] round_clamp(longint num, longint den);
    longint qt;
    longint r;
    if (num >= 0) qt = num / den;
    else qt = -((-num + den - 1) / den);
    r = num - qt * den;
    if (2 * r > den || (2 * r == den && qt[0])) qt++;
    if (qt < 0) return 8'd0;
    if (qt > 255) return 8'd255;
    return qt[7:0];
  endfunction

  // Compute the adjusted pixel for the current amount.
  function automatic res_t adjust_pixel(pix_t p);
    longint ch[3];
    longint mx, mn, d, s, q, v, off, num, den;
    logic [7:0] o[3];
    res_t r;
    ch[0] = p.chan_a; ch[1] = p.chan_b; ch[2] = p.chan_c;
    mx = ch[0]; mn = ch[0];
    for (int i = 1; i < 3; i++) begin
      if (ch[i] > mx) mx = ch[i];
      if (ch[i] < mn) mn = ch[i];
    end
    d = mx - mn;
    s = mx + mn;
    q = (s <= ChanMax) ? s : ChanSpan - s;
    v = sat_amount;
    for (int i = 0; i < 3; i++) begin
      off = 2 * ch[i] - s;
      if (d == 0) begin
        num = ch[i]; den = 1;
      end else if (v > 0) begin
        if (100 * d >= (100 - v) * q) begin
          num = 2 * ch[i] * d + off * (q - d); den = 2 * d;
        end else begin
          num = 2 * ch[i] * (100 - v) + off * v; den = 2 * (100 - v);
        end
      end else begin
        num = 100 * s + off * (100 + v); den = DesatDen;
      end
      o[i] = round_clamp(num, den);
    end
    r.out_a = o[0]; r.out_b = o[1]; r.out_c = o[2];
    return r;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p = pix_t'(24'($urandom));
    // Bias some pixels toward gray and near-extreme values
    case ($urandom_range(0, 5))
      0: begin p.chan_b = p.chan_a; p.chan_c = p.chan_a; end
      1: p.chan_c = p.chan_a;
      2: begin
        p.chan_a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        p.chan_b = 8'($urandom_range(250, 255));
      end
      default: ;
    endcase
    return p;
  endfunction

  // Driver: send queued pixels in bursts with random gaps, predict at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      pix_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) adjusted_q.push_back(adjust_pixel(pix_i));
      if (feed_hold || pixel_q.size() == 0) begin
        start_i <= 1'b0;
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!start_i || !busy_o) begin
        start_i <= 1'b1;
        pix_i <= pixel_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (adjusted_q.size() == 0) begin
        $error("unexpected result %h", res_o);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = adjusted_q.pop_front();
        if (res_o.out_a !== want.out_a) begin
          $error("out_a expected %0d actual %0d", want.out_a, res_o.out_a);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (res_o.out_b !== want.out_b) begin
          $error("out_b expected %0d actual %0d", want.out_b, res_o.out_b);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (res_o.out_c !== want.out_c) begin
          $error("out_c expected %0d actual %0d", want.out_c, res_o.out_c);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  // Wait until every queued pixel has been sent and every result has come.
  task automatic drain();
    while (pixel_q.size() != 0 || start_i || adjusted_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Write the amount register while the pipeline is empty.
  task automatic write_amount(logic signed [7:0] v);
    drain();
    feed_hold = 1'b1;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sat_amount = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    feed_hold = 1'b0;
  endtask

  task automatic queue_directed();
    pix_t p;
    p = '{8'd0, 8'd0, 8'd0};        pixel_q.push_back(p);
    p = '{8'd255, 8'd255, 8'd255};  pixel_q.push_back(p);
    p = '{8'd128, 8'd128, 8'd128};  pixel_q.push_back(p);
    p = '{8'd255, 8'd0, 8'd0};      pixel_q.push_back(p);
    p = '{8'd0, 8'd255, 8'd0};      pixel_q.push_back(p);
    p = '{8'd0, 8'd0, 8'd255};      pixel_q.push_back(p);
    p = '{8'd200, 8'd100, 8'd50};   pixel_q.push_back(p);
    p = '{8'd250, 8'd240, 8'd245};  pixel_q.push_back(p);
    p = '{8'd10, 8'd3, 8'd7};       pixel_q.push_back(p);
    p = '{8'd127, 8'd128, 8'd0};    pixel_q.push_back(p);
    p = '{8'd170, 8'd85, 8'd255};   pixel_q.push_back(p);
  endtask

  initial begin
    logic signed [7:0] amounts[12];
    amounts = '{8'sd0, 8'sd100, -8'sd100, 8'sd50, -8'sd50, 8'sd1, -8'sd1, 8'sd99,
                8'sd127, -8'sd128, 8'sd120, -8'sd110};
    mismatch_cnt = 0;
    feed_hold = 1'b0;
    sat_amount = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed pixels under the reset amount and eleven further amounts, extremes included
    foreach (amounts[k]) begin
      if (k > 0) write_amount(amounts[k]);
      queue_directed();
      drain();
    end
    // Random phases, each with a new amount
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) write_amount(8'($urandom_range(0, 200) - 100));
      else write_amount(8'($urandom_range(0, 255)));
      for (int n = 0; n < 62; n++) pixel_q.push_back(rand_pixel());
    end
    drain();
    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
